// File: hdl/rgbyc_pkg.sv
// Package with the conversion matrix and the fixed-point constants of the RGB to YCbCr packer.
package rgbyc_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int COEF_BITS       = 8;
  localparam int FRAC_BITS       = 7;
  localparam int ROUND_CONST     = 64;
  localparam int SUM_GUARD_BITS  = 9;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  typedef struct packed {
    coef_t c_red;
    coef_t c_green;
    coef_t c_blue;
  } coef_row_t;

  localparam coef_row_t ROW_Y  = '{c_red: 8'sd38,  c_green: 8'sd75,  c_blue: 8'sd15};
  localparam coef_row_t ROW_CB = '{c_red: -8'sd22, c_green: -8'sd42, c_blue: 8'sd64};
  localparam coef_row_t ROW_CR = '{c_red: 8'sd64,  c_green: -8'sd54, c_blue: -8'sd10};

endpackage

// File: hdl/rgbyc_row.sv
// One matrix row: weighted sum, rounding shift, optional chroma offset and clipping.
module rgbyc_row #(
  parameter int SampleBits = rgbyc_pkg::SAMPLE_BITS_DEF
) (
  input  logic [SampleBits-1:0] red_i,
  input  logic [SampleBits-1:0] green_i,
  input  logic [SampleBits-1:0] blue_i,
  input  rgbyc_pkg::coef_row_t  coef_i,
  input  logic                  add_ofs_i,
  output logic [SampleBits-1:0] sample_o
);

  localparam int SW = SampleBits + rgbyc_pkg::SUM_GUARD_BITS;
  localparam logic signed [SW-1:0] RoundVal = SW'(rgbyc_pkg::ROUND_CONST);
  localparam logic signed [SW-1:0] ChromaOfs = SW'(1) <<< (SampleBits - 1);
  localparam logic signed [SW-1:0] MaxVal = (SW'(1) <<< SampleBits) - SW'(1);

  logic signed [SW-1:0] r_s, g_s, b_s;
  logic signed [SW-1:0] sum, shifted, res;

  always_comb begin
    r_s     = $signed(SW'({1'b0, red_i}));
    g_s     = $signed(SW'({1'b0, green_i}));
    b_s     = $signed(SW'({1'b0, blue_i}));
    sum     = r_s * SW'(coef_i.c_red) + g_s * SW'(coef_i.c_green)
            + b_s * SW'(coef_i.c_blue) + RoundVal;
    shifted = sum >>> rgbyc_pkg::FRAC_BITS;
    res     = shifted + (add_ofs_i ? ChromaOfs : '0);
    if (res < 0) begin
      sample_o = '0;
    end else if (res > MaxVal) begin
      sample_o = MaxVal[SampleBits-1:0];
    end else begin
      sample_o = res[SampleBits-1:0];
    end
  end

endmodule

// File: hdl/rgb_to_ycbcr422_packer_unit.sv
// Top level of the RGB to YCbCr 4:2:2 packer with input and result registers.
//
//   channel | valid       | stall       | payload
//   input   | in_valid_i  | in_stall_o  | red_i green_i blue_i frame_start_i
//   result  | out_valid_o | out_stall_i | chroma_sample_o luma_sample_o chroma_is_cr_o
//
// One beat is accepted per cycle while in_stall_o is low; an accepted input beat moves
// from the input register into the result register, where it is presented as a result beat.
// The rate is set by the single pass of the two matrix rows between the input and
// result registers. Reset clears the pixel parity and both valid flags.
// A stalled result holds, and the input register still takes a beat while it is empty.
module rgb_to_ycbcr422_packer_unit #(
  parameter int SampleBits = rgbyc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SampleBits-1:0] red_i,
  input  logic [SampleBits-1:0] green_i,
  input  logic [SampleBits-1:0] blue_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SampleBits-1:0] chroma_sample_o,
  output logic [SampleBits-1:0] luma_sample_o,
  output logic                  chroma_is_cr_o
);

  logic                  parity_q, parity_d;
  logic                  in_valid_q, out_valid_q;
  logic [SampleBits-1:0] red_q, green_q, blue_q;
  logic                  odd_q, odd_d;
  logic [SampleBits-1:0] chroma_q, luma_q;
  logic                  is_cr_q;
  logic [SampleBits-1:0] chroma_d, luma_d;
  logic                  out_ready, in_ready, in_acc;
  rgbyc_pkg::coef_row_t  chroma_coef;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || out_ready;
  assign in_stall_o = !in_ready;
  assign in_acc     = in_valid_i && in_ready;
  assign odd_d      = frame_start_i ? 1'b0 : parity_q;
  assign parity_d   = in_acc ? !odd_d : parity_q;

  assign chroma_coef = odd_q ? rgbyc_pkg::ROW_CR : rgbyc_pkg::ROW_CB;

  rgbyc_row #(.SampleBits(SampleBits)) u_luma (
    .red_i     (red_q),
    .green_i   (green_q),
    .blue_i    (blue_q),
    .coef_i    (rgbyc_pkg::ROW_Y),
    .add_ofs_i (1'b0),
    .sample_o  (luma_d)
  );

  rgbyc_row #(.SampleBits(SampleBits)) u_chroma (
    .red_i     (red_q),
    .green_i   (green_q),
    .blue_i    (blue_q),
    .coef_i    (chroma_coef),
    .add_ofs_i (1'b1),
    .sample_o  (chroma_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q    <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      parity_q <= parity_d;
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      odd_q   <= odd_d;
    end
    if (out_ready && in_valid_q) begin
      chroma_q <= chroma_d;
      luma_q   <= luma_d;
      is_cr_q  <= odd_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chroma_sample_o = chroma_q;
  assign luma_sample_o   = luma_q;
  assign chroma_is_cr_o  = is_cr_q;

`ifndef SYNTHESIS
  a_frame_start_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && frame_start_i |=> !odd_q)
    else $error("Frame start beat was not taken as an even pixel.");

  a_parity_flips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !frame_start_i |=> parity_q != $past(parity_q))
    else $error("Pixel parity did not alternate on an accepted beat.");

  a_stall_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("Input stalled while a register stage was free.");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q)
    else $error("A stalled result beat was dropped.");
`endif

endmodule
